[sv/stwh_pkg.sv]
// Shared constants, types and field widths for the sliding time window histogram.
package stwh_pkg;

  // Store geometry
  localparam int NUM_BINS   = 1024;
  localparam int COUNT_BITS = 32;
  localparam int SLOT_W     = $clog2(NUM_BINS);
  localparam int FILL_W     = SLOT_W + 1;

  // Field and register widths
  localparam int TS_W     = 48;
  localparam int BW_W     = 32;
  localparam int WIN_W    = 48;
  localparam int CFG_W    = 48;
  localparam int STATUS_W = 3;

  // Internal datapath widths
  localparam int FIRST_W = TS_W + 2;              // bin start may run past 2^48
  localparam int NUM_W   = TS_W + 2;              // 2*d + w
  localparam int PROD_W  = SLOT_W + BW_W;         // position * width
  localparam int REM_W   = BW_W + 1 + SLOT_W;     // rounding division remainder
  localparam int STEP_W  = $clog2(TS_W);          // step counter for both dividers

  // Stream packing
  localparam int IN_FIELDS_W  = TS_W + SLOT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_FIELDS_W = SLOT_W + COUNT_BITS + TS_W + COUNT_BITS + FILL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Reset values of the registers
  localparam logic [BW_W-1:0]  BW_RESET  = BW_W'(1000);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1000000);

  // Register indexes
  localparam logic CFG_BIN_WIDTH = 1'b0;
  localparam logic CFG_WINDOW    = 1'b1;

  // Opcodes
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_COUNTED   = 3'd0,
    STAT_FILTERED  = 3'd1,
    STAT_TOO_EARLY = 3'd2,
    STAT_OVERFLOW  = 3'd3,
    STAT_READ_DONE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_READ_DONE,
    S_EVICT_CHK,
    S_EVICT_WR,
    S_ADV_DIV,
    S_ADV_APPLY,
    S_BIN_CHK,
    S_DIV,
    S_INC_RD,
    S_INC_WR,
    S_EMIT
  } fsm_e;

endpackage

[sv/sliding_time_window_histogram_core.sv]
// Flow: a read passes S_READ and S_READ_DONE to its result; an event walks S_EVICT_CHK and
//   S_EVICT_WR once per evicted bin, plus a bit-serial remainder when an empty store has its
//   anchor moved. The bin index comes from a 10-step restoring division, one bit a cycle.
// Throughput: one item at a time; the next beat is taken the cycle after the result is
//   loaded into the output register, which holds it while the master side stalls.
// Reset: control state clears at once, then a clearing pass zeroes the count memory
//   one entry a cycle; no beat is taken until it ends. Config writes are always taken.
module sliding_time_window_histogram_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [stwh_pkg::CFG_W-1:0]         cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [stwh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // timestamp_ns, read_offset
  input  logic [stwh_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // opcode, passes_filter
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [stwh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // bin_position, bin_count,
                                                            // bin_start_ns, window_total,
                                                            // bins_used
  output logic [stwh_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);
  import stwh_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(NUM_BINS - 1);

  fsm_e state_q, state_d;

  // configuration
  logic [BW_W-1:0]  bw_q;
  logic [WIN_W-1:0] win_q;
  logic [BW_W-1:0]  w_eff;

  // histogram state
  logic [SLOT_W-1:0]     oldest_q, oldest_d;
  logic [FILL_W-1:0]     bins_q, bins_d;
  logic [FIRST_W-1:0]    first_q, first_d;
  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [SLOT_W-1:0]     clr_q, clr_d;

  // latched item
  logic [TS_W-1:0]   in_t_q;
  logic [SLOT_W-1:0] in_roff_q;

  // dividers and product
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [TS_W-1:0]   sh_q, sh_d;
  logic [BW_W-1:0]   r_q, r_d;
  logic [REM_W-1:0]  rem_q, rem_d, dsh_q, dsh_d;
  logic [SLOT_W-1:0] q_q, q_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  // pending result
  status_e               res_status_q, res_status_d;
  logic [SLOT_W-1:0]     res_pos_q, res_pos_d;
  logic [COUNT_BITS-1:0] res_cnt_q, res_cnt_d;
  logic [TS_W-1:0]       res_start_q, res_start_d;

  // output register
  logic                  m_valid_q, m_valid_d;
  logic                  out_load;
  status_e               out_status_q;
  logic [SLOT_W-1:0]     out_pos_q;
  logic [COUNT_BITS-1:0] out_cnt_q;
  logic [TS_W-1:0]       out_start_q;
  logic [COUNT_BITS-1:0] out_total_q;
  logic [FILL_W-1:0]     out_used_q;

  // memory port
  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic                  mem_re, mem_we;
  logic [SLOT_W-1:0]     mem_raddr, mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata_q;

  // input unpacking
  logic [TS_W-1:0]   s_t;
  logic [SLOT_W-1:0] s_roff;
  logic              s_op, s_pass, s_beat;

  assign s_t    = s_axis_tdata[TS_W-1:0];
  assign s_roff = s_axis_tdata[TS_W +: SLOT_W];
  assign s_op   = s_axis_tuser[0];
  assign s_pass = s_axis_tuser[1];
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_beat = s_axis_tvalid & s_axis_tready;

  // zero width counts as one
  assign w_eff = (bw_q == '0) ? BW_W'(1) : bw_q;

  // datapath helpers
  logic [FIRST_W-1:0] t_ext, horizon;
  logic               late, t_lt_first, s_lt_first, ovf, rem_ge, r_ge, pad_big;
  logic [TS_W-1:0]    d, need;
  logic [NUM_W-1:0]   num, lim;
  logic [BW_W:0]      r_t;
  logic [BW_W-1:0]    r_n, pad;
  logic [COUNT_BITS-1:0] inc_cnt;

  assign t_ext      = FIRST_W'(in_t_q);
  assign horizon    = first_q + FIRST_W'(win_q);
  assign late       = horizon < t_ext;
  assign t_lt_first = t_ext < first_q;
  assign s_lt_first = FIRST_W'(s_t) < first_q;
  assign d          = in_t_q - first_q[TS_W-1:0];
  assign need       = TS_W'(t_ext - FIRST_W'(win_q) - first_q);
  assign num        = NUM_W'({d, 1'b0}) + NUM_W'(w_eff);
  assign lim        = NUM_W'({w_eff, 1'b0}) << SLOT_W;
  assign ovf        = num >= lim;
  assign rem_ge     = rem_q >= dsh_q;
  assign r_t        = {r_q, sh_q[TS_W-1]};
  assign r_ge       = r_t >= {1'b0, w_eff};
  assign r_n        = r_ge ? BW_W'(r_t - {1'b0, w_eff}) : r_t[BW_W-1:0];
  assign pad        = (r_q == '0) ? '0 : (w_eff - r_q);
  assign pad_big    = WIN_W'(pad) > win_q;
  assign inc_cnt    = (mem_rdata_q == CNT_MAX) ? mem_rdata_q : (mem_rdata_q + 1'b1);
  assign out_load   = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:     if (clr_q == LAST_SLOT) state_d = S_IDLE;
      S_IDLE: begin
        if (s_beat) begin
          if (s_op == OP_READ)  state_d = S_READ;
          else if (!s_pass)     state_d = S_EMIT;
          else if (s_lt_first)  state_d = S_EMIT;
          else                  state_d = S_EVICT_CHK;
        end
      end
      S_READ:      state_d = S_READ_DONE;
      S_READ_DONE: state_d = S_EMIT;
      S_EVICT_CHK: begin
        if (late && bins_q != '0) state_d = S_EVICT_WR;
        else if (late)            state_d = S_ADV_DIV;
        else                      state_d = S_BIN_CHK;
      end
      S_EVICT_WR:  state_d = S_EVICT_CHK;
      S_ADV_DIV:   if (cnt_q == '0) state_d = S_ADV_APPLY;
      S_ADV_APPLY: state_d = S_BIN_CHK;
      S_BIN_CHK: begin
        if (t_lt_first || ovf) state_d = S_EMIT;
        else                   state_d = S_DIV;
      end
      S_DIV:       if (cnt_q == '0) state_d = S_INC_RD;
      S_INC_RD:    state_d = S_INC_WR;
      S_INC_WR:    state_d = S_EMIT;
      S_EMIT:      if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    oldest_d     = oldest_q;
    bins_d       = bins_q;
    first_d      = first_q;
    total_d      = total_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    sh_d         = sh_q;
    r_d          = r_q;
    rem_d        = rem_q;
    dsh_d        = dsh_q;
    q_d          = q_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_cnt_d    = res_cnt_q;
    res_start_d  = res_start_q;
    mem_re       = 1'b0;
    mem_raddr    = oldest_q;
    mem_we       = 1'b0;
    mem_waddr    = oldest_q;
    mem_wdata    = '0;
    case (state_q)
      // zero the store after reset
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      // early outcomes decided on the beat itself
      S_IDLE: begin
        res_pos_d   = '0;
        res_cnt_d   = '0;
        res_start_d = '0;
        if (!s_pass) res_status_d = STAT_FILTERED;
        else         res_status_d = STAT_TOO_EARLY;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = oldest_q + in_roff_q;
        prod_d    = PROD_W'(in_roff_q) * PROD_W'(w_eff);
      end
      S_READ_DONE: begin
        res_status_d = STAT_READ_DONE;
        res_pos_d    = in_roff_q;
        res_cnt_d    = (FILL_W'(in_roff_q) < bins_q) ? mem_rdata_q : '0;
        res_start_d  = TS_W'(first_q + FIRST_W'(prod_q));
      end
      // eviction: read oldest bin, then clear it and drop it from the total
      S_EVICT_CHK: begin
        if (late && bins_q != '0) begin
          mem_re = 1'b1;
        end else if (late) begin
          sh_d  = need;
          r_d   = '0;
          cnt_d = STEP_W'(TS_W - 1);
        end
      end
      S_EVICT_WR: begin
        total_d  = (mem_rdata_q > total_q) ? '0 : (total_q - mem_rdata_q);
        mem_we   = 1'b1;
        oldest_d = oldest_q + 1'b1;
        bins_d   = bins_q - 1'b1;
        if (bins_q != FILL_W'(1)) first_d = first_q + FIRST_W'(w_eff);
      end
      // need mod width, one bit a cycle
      S_ADV_DIV: begin
        r_d   = r_n;
        sh_d  = {sh_q[TS_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
      end
      // round the anchor up to a bin multiple, backing off one bin if that passes t
      S_ADV_APPLY: begin
        if (pad_big) first_d = first_q + FIRST_W'(need) - FIRST_W'(r_q);
        else         first_d = first_q + FIRST_W'(need) + FIRST_W'(pad);
      end
      S_BIN_CHK: begin
        res_pos_d   = '0;
        res_cnt_d   = '0;
        res_start_d = '0;
        if (t_lt_first) res_status_d = STAT_TOO_EARLY;
        else            res_status_d = STAT_OVERFLOW;
        rem_d = REM_W'(num);
        dsh_d = REM_W'(lim >> 1);
        q_d   = '0;
        cnt_d = STEP_W'(SLOT_W - 1);
      end
      // restoring division for round((t - first) / w)
      S_DIV: begin
        if (rem_ge) rem_d = rem_q - dsh_q;
        dsh_d = dsh_q >> 1;
        q_d   = {q_q[SLOT_W-2:0], rem_ge};
        cnt_d = cnt_q - 1'b1;
      end
      S_INC_RD: begin
        mem_re    = 1'b1;
        mem_raddr = oldest_q + q_q;
        prod_d    = PROD_W'(q_q) * PROD_W'(w_eff);
        if (FILL_W'(q_q) >= bins_q) bins_d = FILL_W'(q_q) + 1'b1;
      end
      S_INC_WR: begin
        mem_we       = 1'b1;
        mem_waddr    = oldest_q + q_q;
        mem_wdata    = inc_cnt;
        total_d      = (total_q == CNT_MAX) ? total_q : (total_q + 1'b1);
        res_status_d = STAT_COUNTED;
        res_pos_d    = q_q;
        res_cnt_d    = inc_cnt;
        res_start_d  = TS_W'(first_q + FIRST_W'(prod_q));
      end
      default: ;
    endcase
  end

  // output valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load)           m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  // count memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  // control and histogram state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      bw_q      <= BW_RESET;
      win_q     <= WIN_RESET;
      oldest_q  <= '0;
      bins_q    <= '0;
      first_q   <= '0;
      total_q   <= '0;
      clr_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      bins_q    <= bins_d;
      first_q   <= first_d;
      total_q   <= total_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BIN_WIDTH) bw_q <= cfg_wdata_i[BW_W-1:0];
        else                            win_q <= cfg_wdata_i[WIN_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_t_q    <= s_t;
      in_roff_q <= s_roff;
    end
    sh_q         <= sh_d;
    r_q          <= r_d;
    rem_q        <= rem_d;
    dsh_q        <= dsh_d;
    q_q          <= q_d;
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_cnt_q    <= res_cnt_d;
    res_start_q  <= res_start_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_pos_q    <= res_pos_q;
      out_cnt_q    <= res_cnt_q;
      out_start_q  <= res_start_q;
      out_total_q  <= total_q;
      out_used_q   <= bins_q;
    end
  end

  // result packing
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                          out_used_q, out_total_q, out_start_q, out_cnt_q, out_pos_q};

endmodule

[tb/sv/sliding_time_window_histogram_core_test.sv]
`timescale 1ns / 100ps
// Self-checking stream testbench for the sliding time window histogram core.
module sliding_time_window_histogram_core_test;
  import stwh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam logic [TS_W-1:0] TS_MAX  = '1;
  localparam logic [63:0] COUNT_MAX   = (64'd1 << COUNT_BITS) - 64'd1;

  // result tdata field offsets, lowest first
  localparam int POS_LO   = 0;
  localparam int CNT_LO   = POS_LO + SLOT_W;
  localparam int START_LO = CNT_LO + COUNT_BITS;
  localparam int TOTAL_LO = START_LO + TS_W;
  localparam int USED_LO  = TOTAL_LO + COUNT_BITS;

  typedef struct packed {
    logic              opcode;
    logic [TS_W-1:0]   stamp;
    logic              pass;
    logic [SLOT_W-1:0] offset;
  } hist_req_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_W-1:0]     position;
    logic [COUNT_BITS-1:0] count;
    logic [TS_W-1:0]       start;
    logic [COUNT_BITS-1:0] total;
    logic [FILL_W-1:0]     used;
  } hist_result_t;

  // Mirror of the bin ring plus the queue of results still owed by the core
  class hist_scoreboard;
    logic [COUNT_BITS-1:0] bin_cnt [NUM_BINS];
    int unsigned           head_slot;
    int unsigned           held;
    logic [63:0]           anchor;     // start of the oldest bin, kept wide
    logic [63:0]           total;
    logic [BW_W-1:0]       width_reg;
    logic [WIN_W-1:0]      window_reg;
    hist_result_t          pending_q[$];
    int unsigned           n_errors;
    int unsigned           n_checked;
    int unsigned           status_tally[5];

    function new();
      foreach (bin_cnt[i]) bin_cnt[i] = '0;
      foreach (status_tally[i]) status_tally[i] = 0;
      head_slot  = 0;
      held       = 0;
      anchor     = '0;
      total      = '0;
      width_reg  = BW_RESET;
      window_reg = WIN_RESET;
      n_errors   = 0;
      n_checked  = 0;
    endfunction

    function logic [63:0] bin_width();
      return (width_reg == '0) ? 64'd1 : 64'(width_reg);
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_BIN_WIDTH) width_reg = value[BW_W-1:0];
      else window_reg = value[WIN_W-1:0];
    endfunction

    function int unsigned slot(int unsigned pos);
      return (head_slot + pos) % NUM_BINS;
    endfunction

    // Apply one accepted beat to the mirror and queue the result it owes
    function void accept_request(hist_req_t req);
      hist_result_t res;
      logic [63:0]  w, win, t, d, idx, need, n_in, n_cap;
      int unsigned  s;
      w   = bin_width();
      win = 64'(window_reg);
      t   = 64'(req.stamp);
      res = '0;
      if (req.opcode == OP_READ) begin
        res.status   = STAT_READ_DONE;
        res.position = req.offset;
        if (req.offset < held) res.count = bin_cnt[slot(req.offset)];
        res.start = TS_W'(anchor + 64'(req.offset) * w);
      end else if (!req.pass) begin
        res.status = STAT_FILTERED;
      end else if (t < anchor) begin
        res.status = STAT_TOO_EARLY;
      end else begin
        // retire leading bins that fell out of the window
        while (held > 0 && anchor + win < t) begin
          s = slot(0);
          total = (64'(bin_cnt[s]) > total) ? 64'd0 : total - 64'(bin_cnt[s]);
          bin_cnt[s] = '0;
          head_slot = (head_slot + 1) % NUM_BINS;
          held--;
          if (held > 0) anchor += w;
        end
        // empty store: pull the anchor up to the window, never past the event
        if (held == 0 && anchor + win < t) begin
          need  = t - win - anchor;
          n_in  = (need + w - 1) / w;
          n_cap = (t - anchor) / w;
          anchor += ((n_in < n_cap) ? n_in : n_cap) * w;
        end
        if (t < anchor) begin
          res.status = STAT_TOO_EARLY;
        end else begin
          d   = t - anchor;
          idx = (2 * d + w) / (2 * w);   // round half up
          if (idx >= NUM_BINS) begin
            res.status = STAT_OVERFLOW;
          end else begin
            if (idx >= held) held = int'(idx[SLOT_W-1:0]) + 1;
            s = slot(idx[SLOT_W-1:0]);
            if (bin_cnt[s] != '1) bin_cnt[s] += 1'b1;
            if (total < COUNT_MAX) total++;
            res.status   = STAT_COUNTED;
            res.position = idx[SLOT_W-1:0];
            res.count    = bin_cnt[s];
            res.start    = TS_W'(anchor + idx * w);
          end
        end
      end
      res.total = total[COUNT_BITS-1:0];
      res.used  = FILL_W'(held);
      pending_q.insert(pending_q.size(), res);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        n_errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    // Compare one result beat against the oldest owed result
    function void check_result(logic [STATUS_W-1:0] st, logic [OUT_TDATA_W-1:0] data);
      hist_result_t want;
      if (pending_q.size() == 0) begin
        n_errors++;
        $error("result beat with nothing expected: status %0d", st);
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      status_tally[want.status]++;
      compare_field("status", 64'(want.status), 64'(st));
      compare_field("bin_position", 64'(want.position), 64'(data[POS_LO +: SLOT_W]));
      compare_field("bin_count", 64'(want.count), 64'(data[CNT_LO +: COUNT_BITS]));
      compare_field("bin_start_ns", 64'(want.start), 64'(data[START_LO +: TS_W]));
      compare_field("window_total", 64'(want.total), 64'(data[TOTAL_LO +: COUNT_BITS]));
      compare_field("bins_used", 64'(want.used), 64'(data[USED_LO +: FILL_W]));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // timestamp_ns, read_offset
  logic [IN_TUSER_W-1:0]  s_axis_tuser;   // opcode, passes_filter
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // bin_position, bin_count, bin_start_ns,
                                          // window_total, bins_used
  logic [STATUS_W-1:0]    m_axis_tuser;   // status

  hist_scoreboard sb;
  logic           send_idle;
  logic           recv_idle;
  logic [63:0]    cursor;      // running event time for well-formed traffic
  int unsigned    n_sent;

  sliding_time_window_histogram_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [TS_W-1:0] clip_ts(logic [63:0] v);
    return (v > 64'(TS_MAX)) ? TS_MAX : v[TS_W-1:0];
  endfunction

  function automatic logic [63:0] rand_below(logic [63:0] bound);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return (bound == '0) ? 64'd0 : r % bound;
  endfunction

  function automatic hist_req_t make_req(logic op, logic [63:0] stamp, logic pass,
                                         logic [SLOT_W-1:0] offset);
    hist_req_t r;
    r.opcode = op;
    r.stamp  = clip_ts(stamp);
    r.pass   = pass;
    r.offset = offset;
    return r;
  endfunction

  // Offer one beat, after a random gap if send_idle; the mirror is updated at acceptance
  task automatic send_beat(hist_req_t req);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({req.offset, req.stamp});
    s_axis_tuser  <= {req.pass, req.opcode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.accept_request(req);
    n_sent++;
  endtask

  // Mostly advancing events around the current anchor, with reads and noise mixed in
  task automatic send_random(int unsigned count);
    hist_req_t   req;
    logic [63:0] w, win, base, back;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      w    = sb.bin_width();
      win  = 64'(sb.window_reg);
      base = (cursor > sb.anchor) ? cursor : sb.anchor;
      pick = $urandom_range(0, 99);
      req  = make_req(OP_EVENT, {$urandom, $urandom}, 1'b1, SLOT_W'($urandom));
      if (pick < 15) begin
        req.opcode = OP_READ;
        req.pass   = 1'($urandom);
        if (sb.held > 0 && $urandom_range(0, 3) != 0)
          req.offset = SLOT_W'($urandom_range(0, sb.held - 1));
      end else if (pick < 20) begin
        req.pass = 1'b0;
      end else if (pick < 24) begin
        req.stamp = clip_ts(rand_below(sb.anchor));
      end else if (pick < 27) begin
        // jump past the window: full eviction then anchor catch-up
        cursor    = base + win + rand_below(3 * win + 1);
        req.stamp = clip_ts(cursor);
      end else if (pick < 31) begin
        // land near the far end of the ring
        req.stamp = clip_ts(sb.anchor + w * (900 + $urandom_range(0, 200)) + rand_below(w));
      end else begin
        cursor    = base + rand_below(2 * w + 1);
        back      = rand_below(w / 2 + 1);
        req.stamp = clip_ts((cursor > back) ? cursor - back : 64'd0);
      end
      send_beat(req);
    end
  endtask

  // Stop offering and let every owed result come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off once traffic is flowing
  initial begin : result_sink
    int unsigned gap;
    bit          long_hold_done;
    m_axis_tready  = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = recv_idle ? $urandom_range(0, 8) : 0;
      if (!long_hold_done && sb.n_checked >= 300) begin
        gap            = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_BIN_WIDTH;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    cursor        = '0;
    n_sent        = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: empty reads, rounding, growth, eviction walk, too early
    send_beat(make_req(OP_READ, 64'd0, 1'b0, '0));
    send_beat(make_req(OP_READ, 64'(TS_MAX), 1'b1, '1));
    send_beat(make_req(OP_EVENT, 64'(TS_MAX), 1'b0, '1));
    send_beat(make_req(OP_EVENT, 64'd0, 1'b1, '0));
    send_beat(make_req(OP_EVENT, 64'd499, 1'b1, '0));
    send_beat(make_req(OP_EVENT, 64'd500, 1'b1, '0));
    send_beat(make_req(OP_EVENT, 64'd1_000_000, 1'b1, '0));
    send_beat(make_req(OP_EVENT, 64'd1_023_400, 1'b1, '0));
    send_beat(make_req(OP_EVENT, 64'd0, 1'b1, '0));
    send_beat(make_req(OP_READ, 64'd0, 1'b1, SLOT_W'(0)));
    send_beat(make_req(OP_READ, 64'd0, 1'b0, SLOT_W'(999)));
    send_beat(make_req(OP_EVENT, 64'd5_000_000, 1'b1, '0));
    cursor = 64'd5_000_000;
    send_random(220);

    // zero width counts as one; window wider than the ring gives overflow
    drain();
    write_cfg(CFG_BIN_WIDTH, '0);
    write_cfg(CFG_WINDOW, CFG_W'(2000));
    send_beat(make_req(OP_EVENT, sb.anchor + 64'd1030, 1'b1, '0));
    send_beat(make_req(OP_EVENT, sb.anchor + 64'd5, 1'b1, '0));
    send_random(150);

    // hold at least two bins, then shrink the window below one bin width
    drain();
    write_cfg(CFG_BIN_WIDTH, CFG_W'(1000));
    write_cfg(CFG_WINDOW, CFG_W'(1500));
    send_beat(make_req(OP_EVENT, sb.anchor, 1'b1, '0));
    send_beat(make_req(OP_EVENT, sb.anchor + 64'd1000, 1'b1, '0));
    drain();
    write_cfg(CFG_WINDOW, CFG_W'(1));
    // eviction moves the anchor past this event
    send_beat(make_req(OP_EVENT, sb.anchor + 64'd2, 1'b1, '0));
    send_random(100);

    drain();
    write_cfg(CFG_BIN_WIDTH, CFG_W'(7));
    write_cfg(CFG_WINDOW, CFG_W'(5000));
    send_random(180);

    // widest bins near the top of the time range: starts wrap past 48 bits
    drain();
    write_cfg(CFG_BIN_WIDTH, CFG_W'(32'hFFFF_FFFF));
    write_cfg(CFG_WINDOW, CFG_W'(1));
    send_beat(make_req(OP_EVENT, 64'(TS_MAX), 1'b1, '0));
    send_beat(make_req(OP_READ, 64'd0, 1'b1, '1));
    send_beat(make_req(OP_READ, 64'd0, 1'b0, '0));
    send_random(20);

    drain();
    write_cfg(CFG_WINDOW, CFG_W'(TS_MAX));
    send_beat(make_req(OP_EVENT, 64'(TS_MAX), 1'b1, '0));
    send_beat(make_req(OP_READ, 64'd0, 1'b1, '1));
    send_random(80);
    drain();

    $display("Run: %0d beats over seven register settings, %s", n_sent,
             "bin width 0 to full scale, window 1 to full scale.");
    $display("Checked %0d counted, %0d filtered, %0d too early, %0d overflow, %0d reads.",
             sb.status_tally[STAT_COUNTED], sb.status_tally[STAT_FILTERED],
             sb.status_tally[STAT_TOO_EARLY], sb.status_tally[STAT_OVERFLOW],
             sb.status_tally[STAT_READ_DONE]);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
sv/stwh_pkg.sv
sv/sliding_time_window_histogram_core.sv
tb/sv/sliding_time_window_histogram_core_test.sv
